// File: rtl/gfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_pkg: shared types and constants
// Register indexes, polynomial coefficients and default sizes for the foot
// trajectory point generator.
// ----------------------------------------------------------------------------
package gfp_pkg;

    // default sizes
    localparam int PHASE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // field widths fixed by the interface
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 24;
    localparam int AMP_W    = 15;
    localparam int COORD_W  = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000;

    // sine lane depth in registers
    localparam int LANE_LAT = 8;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRIDE = 2'd0,
        REG_LIFT   = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_PERIOD = 2'd3
    } t_cfg_reg;

    // quarter-sine polynomial, Q30
    localparam logic [31:0] COEF9 = 32'd172272;
    localparam logic [31:0] HORNER_COEF [4] = '{
        32'd5026994, 32'd85569305, 32'd693598667, 32'd1686629713
    };

endpackage

// File: rtl/gfp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the period
// when it fits and shifts the quotient bit into the word.
// ----------------------------------------------------------------------------
module gfp_div_cell import gfp_pkg::*; #(
    parameter int W         = 32,
    parameter bit FEED_ZERO = 1'b0,
    parameter bit SET_FLAG  = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [PERIOD_W-1:0] i_rem,
    input  logic [W-1:0]        i_word,
    input  logic                i_flag,
    output logic [PERIOD_W-1:0] o_rem,
    output logic [W-1:0]        o_word,
    output logic                o_flag
);

    logic [PERIOD_W-1:0] r_rem;
    logic [W-1:0]        r_word;
    logic                r_flag;
    logic                w_bit;
    logic [PERIOD_W:0]   w_r2;
    logic [PERIOD_W:0]   w_p;
    logic                w_ge;
    logic [PERIOD_W-1:0] n_rem;
    logic                n_flag;

    // trial subtract
    always_comb begin
        w_bit  = FEED_ZERO ? 1'b0 : i_word[W-1];
        w_r2   = {i_rem, w_bit};
        w_p    = {1'b0, i_period};
        w_ge   = (w_r2 >= w_p);
        n_rem  = w_ge ? PERIOD_W'(w_r2 - w_p) : w_r2[PERIOD_W-1:0];
        // swing when twice the remainder exceeds the period
        n_flag = SET_FLAG ? (w_r2 > w_p) : i_flag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_word <= {i_word[W-2:0], w_ge};
            r_flag <= n_flag;
        end
    end

    assign o_rem  = r_rem;
    assign o_word = r_word;
    assign o_flag = r_flag;

endmodule

// File: rtl/gfp_horner_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_horner_cell: one Horner step of the quarter-sine polynomial
// Computes COEF - (s * u2) >> 16 and passes the operands on.
// ----------------------------------------------------------------------------
module gfp_horner_cell import gfp_pkg::*; #(
    parameter logic [31:0] COEF = 32'd0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_s,
    input  logic [16:0] i_u2,
    input  logic [16:0] i_u,
    input  logic        i_neg,
    output logic [31:0] o_s,
    output logic [16:0] o_u2,
    output logic [16:0] o_u,
    output logic        o_neg
);

    logic [48:0] w_prod;
    logic [31:0] r_s;
    logic [16:0] r_u2;
    logic [16:0] r_u;
    logic        r_neg;

    assign w_prod = 49'(i_s) * 49'(i_u2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s   <= COEF - 32'(w_prod >> 16);
            r_u2  <= i_u2;
            r_u   <= i_u;
            r_neg <= i_neg;
        end
    end

    assign o_s   = r_s;
    assign o_u2  = r_u2;
    assign o_u   = r_u;
    assign o_neg = r_neg;

endmodule

// File: rtl/gfp_sine_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_sine_lane: scaled sine of a turn fraction
// Folds the angle to a quarter turn, evaluates the polynomial through a row
// of Horner cells and scales by the amplitude. Gives magnitude and sign.
// ----------------------------------------------------------------------------
module gfp_sine_lane import gfp_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [PHASE_BITS-1:0] i_angle,
    input  logic [AMP_W-1:0]      i_amp,
    output logic [COORD_W-1:0]    o_mag,
    output logic                  o_neg
);

    localparam int QB = PHASE_BITS - 2;

    logic [QB+15:0] w_fx;
    logic [16:0]    w_u;
    logic [16:0]    r_u;
    logic           r_neg;
    logic [33:0]    w_uu;
    logic [31:0]    s_s   [5];
    logic [16:0]    s_u2  [5];
    logic [16:0]    s_u   [5];
    logic           s_neg [5];
    logic [48:0]    w_su;
    logic [32:0]    r_r;
    logic           r_neg_r;
    logic [33:0]    w_rr;
    logic [18:0]    w_q;
    logic [AMP_W-1:0] w_m;
    logic [29:0]    r_prod;
    logic           r_neg_p;
    logic [30:0]    w_pr;

    // quarter-turn fold
    always_comb begin
        w_fx = {i_angle[QB-1:0], 16'b0};
        w_u  = 17'(w_fx >> QB);
        if (i_angle[QB]) begin
            w_u = 17'h10000 - w_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u   <= w_u;
            r_neg <= i_angle[QB+1];
        end
    end

    // square of u, seed of Horner chain
    assign w_uu = 34'(r_u) * 34'(r_u);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            s_s[0]   <= COEF9;
            s_u2[0]  <= 17'(w_uu >> 16);
            s_u[0]   <= r_u;
            s_neg[0] <= r_neg;
        end
    end

    // Horner cells
    for (genvar g = 0; g < 4; g++) begin : g_horner
        gfp_horner_cell #(.COEF(HORNER_COEF[g])) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_s   (s_s[g]),
            .i_u2  (s_u2[g]),
            .i_u   (s_u[g]),
            .i_neg (s_neg[g]),
            .o_s   (s_s[g+1]),
            .o_u2  (s_u2[g+1]),
            .o_u   (s_u[g+1]),
            .o_neg (s_neg[g+1])
        );
    end

    // final odd term
    assign w_su = 49'(s_s[4]) * 49'(s_u[4]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r     <= 33'(w_su >> 16);
            r_neg_r <= s_neg[4];
        end
    end

    // round to Q15, cap, scale by amplitude
    always_comb begin
        w_rr = 34'(r_r) + 34'd16384;
        w_q  = 19'(w_rr >> 15);
        w_m  = (w_q > 19'd32767) ? 15'h7FFF : w_q[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= 30'(i_amp) * 30'(w_m);
            r_neg_p <= r_neg_r;
        end
    end

    // magnitude never exceeds 32767
    assign w_pr  = 31'(r_prod) + 31'd16384;
    assign o_mag = 16'(w_pr >> 15);
    assign o_neg = r_neg_p;

endmodule

// File: rtl/gait_foot_trajectory_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gait_foot_trajectory_point: elliptical foot trajectory point generator
// One point per time request: forward and lift coordinates on an ellipse,
// height from configuration, and the stand/swing flag.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not held and returns
// one point per request, in order. A row of TIME_BITS + PHASE_BITS
// division cells forms the remainder and progress one bit per cell, then
// two eight-stage sine lanes and an output register. A stalled output
// holds the whole pipeline. Configuration is to be written with i_cfg_we,
// i_cfg_index and i_cfg_data only while no request is in flight; not enforced.
module gait_foot_trajectory_point import gfp_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [TIME_W-1:0]         i_time_ticks,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_foot_x,
    output logic signed [COORD_W-1:0] o_foot_y,
    output logic signed [COORD_W-1:0] o_foot_z,
    output logic                      o_phase_is_swing
);

    localparam int W  = (TIME_BITS > PHASE_BITS) ? TIME_BITS : PHASE_BITS;
    localparam int NC = TIME_BITS + PHASE_BITS;
    localparam int L  = NC + LANE_LAT;

    logic [AMP_W-1:0]    r_stride;
    logic [AMP_W-1:0]    r_lift;
    logic [COORD_W-1:0]  r_height;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] w_period;
    logic                w_en;
    logic [L-1:0]        r_vld;
    logic [TIME_BITS+TIME_W-1:0] w_t_ext;
    logic [PERIOD_W-1:0] c_rem  [NC+1];
    logic [W-1:0]        c_word [NC+1];
    logic                c_flag [NC+1];
    logic [PHASE_BITS-1:0] w_angle;
    logic [PHASE_BITS-1:0] w_cos_angle;
    logic [LANE_LAT-1:0] r_swing;
    logic [COORD_W-1:0]  w_x_mag;
    logic                w_x_neg;
    logic [COORD_W-1:0]  w_z_mag;
    logic                w_z_neg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= '0;
            r_lift   <= '0;
            r_height <= '0;
            r_period <= PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_STRIDE: r_stride <= i_cfg_data[AMP_W-1:0];
                REG_LIFT:   r_lift   <= i_cfg_data[AMP_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[COORD_W-1:0];
                REG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero period behaves as one
    assign w_period = (r_period == '0) ? PERIOD_W'(1) : r_period;

    // whole pipeline moves unless the output is held
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_in_valid};
        end
    end

    // chain head: time at the top of the word
    assign w_t_ext   = {{TIME_BITS{1'b0}}, i_time_ticks};
    assign c_rem[0]  = '0;
    assign c_word[0] = W'(w_t_ext[TIME_BITS-1:0]) << (W - TIME_BITS);
    assign c_flag[0] = 1'b0;

    // division cells: remainder, then progress bits
    for (genvar g = 0; g < NC; g++) begin : g_div
        gfp_div_cell #(
            .W         (W),
            .FEED_ZERO (g >= TIME_BITS),
            .SET_FLAG  (g == TIME_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_period (w_period),
            .i_rem    (c_rem[g]),
            .i_word   (c_word[g]),
            .i_flag   (c_flag[g]),
            .o_rem    (c_rem[g+1]),
            .o_word   (c_word[g+1]),
            .o_flag   (c_flag[g+1])
        );
    end

    assign w_angle     = c_word[NC][PHASE_BITS-1:0];
    assign w_cos_angle = w_angle + {2'b01, {(PHASE_BITS-2){1'b0}}};

    // swing flag follows the lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_swing <= {r_swing[LANE_LAT-2:0], c_flag[NC]};
        end
    end

    gfp_sine_lane #(.PHASE_BITS(PHASE_BITS)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_cos_angle),
        .i_amp   (r_stride),
        .o_mag   (w_x_mag),
        .o_neg   (w_x_neg)
    );

    gfp_sine_lane #(.PHASE_BITS(PHASE_BITS)) u_lane_z (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_angle),
        .i_amp   (r_lift),
        .o_mag   (w_z_mag),
        .o_neg   (w_z_neg)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= r_vld[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_foot_x         <= w_x_neg ? -w_x_mag : w_x_mag;
            o_foot_y         <= r_height;
            o_foot_z         <= r_swing[LANE_LAT-1] ? (w_z_neg ? -w_z_mag : w_z_mag) : '0;
            o_phase_is_swing <= r_swing[LANE_LAT-1];
        end
    end

    // stand points carry no lift
    a_stand_flat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_phase_is_swing |-> o_foot_z == '0)
        else $error("lift non-zero in stand");

    // height tracks the register
    a_height : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_foot_y == r_height)
        else $error("height differs from register");

    // zero stride gives no forward motion
    a_zero_stride : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_stride == '0 |-> o_foot_x == '0)
        else $error("forward coordinate with zero stride");

endmodule
